// ----- src/dinit_pkg.sv -----
package dinit_pkg;

  // one request on the input channel
  typedef struct packed {
    logic [7:0] op_byte;
    logic       last_in_list;
  } dinit_in_t;

  // one bus action on the result channel
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] action_value;
  } dinit_out_t;

  // parse phase codes
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_CMD8    = 3'd1;
  localparam logic [2:0] PH_C16_HI  = 3'd2;
  localparam logic [2:0] PH_C16_LO  = 3'd3;
  localparam logic [2:0] PH_RUN_LEN = 3'd4;
  localparam logic [2:0] PH_RUN     = 3'd5;
  localparam logic [2:0] PH_DELAY   = 3'd6;
  localparam logic [2:0] PH_C8_LEN  = 3'd7;

  // action codes
  localparam logic [2:0] ACT_BEGIN   = 3'd0;
  localparam logic [2:0] ACT_END     = 3'd1;
  localparam logic [2:0] ACT_CMD8    = 3'd2;
  localparam logic [2:0] ACT_CMD16   = 3'd3;
  localparam logic [2:0] ACT_CBYTE   = 3'd4;
  localparam logic [2:0] ACT_DBYTE   = 3'd5;
  localparam logic [2:0] ACT_DELAY   = 3'd6;
  localparam logic [2:0] ACT_UNKNOWN = 3'd7;

  // opcodes of the operation list
  localparam logic [7:0] OP_BEGIN     = 8'd0;
  localparam logic [7:0] OP_CMD8      = 8'd1;
  localparam logic [7:0] OP_CMD16     = 8'd2;
  localparam logic [7:0] OP_CMD_RUN   = 8'd3;
  localparam logic [7:0] OP_DATA8     = 8'd4;
  localparam logic [7:0] OP_DATA16    = 8'd5;
  localparam logic [7:0] OP_DATA_RUN  = 8'd6;
  localparam logic [7:0] OP_C8_D8     = 8'd7;
  localparam logic [7:0] OP_C8_D16    = 8'd8;
  localparam logic [7:0] OP_C8_RUN    = 8'd9;
  localparam logic [7:0] OP_C16_D16   = 8'd10;
  localparam logic [7:0] OP_END       = 8'd11;
  localparam logic [7:0] OP_DELAY     = 8'd12;

endpackage

// ----- src/display_init_op_stream_decoder.sv -----
// an accepted byte's action is registered and appears on out_data in the next cycle
// throughput: one list byte per cycle while in_stall is low; the parse state updates in the same cycle
// a byte that yields no action is still taken and gives no output request
// in_stall is high only while a held action is stalled at the output
// reset (rst_n low, synchronous) returns the parser to the opcode phase, output empty
module display_init_op_stream_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dinit_pkg::dinit_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dinit_pkg::dinit_out_t out_data
);
  import dinit_pkg::*;

  logic       take;
  logic       res_valid;
  dinit_out_t res;
  logic       busy;

  assign in_stall = busy;
  assign take     = in_valid & ~busy;

  // byte parser
  dinit_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .req       (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  dinit_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/dinit_parser.sv -----
module dinit_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  dinit_pkg::dinit_in_t  req,
  output logic                res_valid,
  output dinit_pkg::dinit_out_t res
);
  import dinit_pkg::*;

  logic [2:0] phase_r,    phase_nxt;
  logic [7:0] remain_r,   remain_nxt;
  logic       run_cmd_r,  run_cmd_nxt;
  logic [1:0] data_cnt_r, data_cnt_nxt;
  logic [7:0] high_r,     high_nxt;
  logic [7:0] b;
  logic [7:0] remain_dec;

  assign b          = req.op_byte;
  assign remain_dec = remain_r - 8'd1;

  // phase update and action decode for one list byte
  always_comb begin
    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    run_cmd_nxt  = run_cmd_r;
    data_cnt_nxt = data_cnt_r;
    high_nxt     = high_r;
    res_valid    = 1'b0;
    res          = '0;
    if (take) begin
      unique case (phase_r) inside
        PH_CMD8, PH_C16_LO: begin
          res_valid = 1'b1;
          if (phase_r == PH_CMD8) begin
            res.action       = ACT_CMD8;
            res.action_value = {8'h00, b};
          end else begin
            res.action       = ACT_CMD16;
            res.action_value = {high_r, b};
          end
          // trailing data bytes after the command, if any
          if (data_cnt_r != 2'd0) begin
            remain_nxt  = {6'd0, data_cnt_r};
            run_cmd_nxt = 1'b0;
            phase_nxt   = PH_RUN;
          end else begin
            phase_nxt = PH_OPCODE;
          end
          data_cnt_nxt = 2'd0;
        end
        PH_C16_HI: begin
          high_nxt  = b;
          phase_nxt = PH_C16_LO;
        end
        PH_RUN_LEN: begin
          remain_nxt = b;
          phase_nxt  = (b != 8'd0) ? PH_RUN : PH_OPCODE;
        end
        PH_RUN: begin
          res_valid        = 1'b1;
          res.action       = run_cmd_r ? ACT_CBYTE : ACT_DBYTE;
          res.action_value = {8'h00, b};
          remain_nxt       = remain_dec;
          if (remain_dec == 8'd0) phase_nxt = PH_OPCODE;
        end
        PH_DELAY: begin
          res_valid        = 1'b1;
          res.action       = ACT_DELAY;
          res.action_value = {8'h00, b};
          phase_nxt        = PH_OPCODE;
        end
        PH_C8_LEN: begin
          res_valid        = 1'b1;
          res.action       = ACT_CMD8;
          res.action_value = {8'h00, b};
          run_cmd_nxt      = 1'b0;
          phase_nxt        = PH_RUN_LEN;
        end
        default: begin
          // opcode phase
          phase_nxt = PH_OPCODE;
          unique case (b)
            OP_BEGIN: begin
              res_valid  = 1'b1;
              res.action = ACT_BEGIN;
            end
            OP_END: begin
              res_valid  = 1'b1;
              res.action = ACT_END;
            end
            OP_CMD8: begin
              data_cnt_nxt = 2'd0;
              phase_nxt    = PH_CMD8;
            end
            OP_C8_D8: begin
              data_cnt_nxt = 2'd1;
              phase_nxt    = PH_CMD8;
            end
            OP_C8_D16: begin
              data_cnt_nxt = 2'd2;
              phase_nxt    = PH_CMD8;
            end
            OP_CMD16: begin
              data_cnt_nxt = 2'd0;
              phase_nxt    = PH_C16_HI;
            end
            OP_C16_D16: begin
              data_cnt_nxt = 2'd2;
              phase_nxt    = PH_C16_HI;
            end
            OP_CMD_RUN: begin
              run_cmd_nxt = 1'b1;
              phase_nxt   = PH_RUN_LEN;
            end
            OP_DATA_RUN: begin
              run_cmd_nxt = 1'b0;
              phase_nxt   = PH_RUN_LEN;
            end
            OP_DATA8: begin
              run_cmd_nxt = 1'b0;
              remain_nxt  = 8'd1;
              phase_nxt   = PH_RUN;
            end
            OP_DATA16: begin
              run_cmd_nxt = 1'b0;
              remain_nxt  = 8'd2;
              phase_nxt   = PH_RUN;
            end
            OP_C8_RUN: phase_nxt = PH_C8_LEN;
            OP_DELAY:  phase_nxt = PH_DELAY;
            default: begin
              res_valid        = 1'b1;
              res.action       = ACT_UNKNOWN;
              res.action_value = {8'h00, b};
            end
          endcase
        end
      endcase
      // last byte of the list drops any half-read operation
      if (req.last_in_list) begin
        phase_nxt    = PH_OPCODE;
        remain_nxt   = 8'd0;
        run_cmd_nxt  = 1'b0;
        data_cnt_nxt = 2'd0;
        high_nxt     = 8'd0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPCODE;
      remain_r   <= 8'd0;
      run_cmd_r  <= 1'b0;
      data_cnt_r <= 2'd0;
      high_r     <= 8'd0;
    end else begin
      phase_r    <= phase_nxt;
      remain_r   <= remain_nxt;
      run_cmd_r  <= run_cmd_nxt;
      data_cnt_r <= data_cnt_nxt;
      high_r     <= high_nxt;
    end
  end

endmodule

// ----- src/dinit_out_reg.sv -----
module dinit_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  dinit_pkg::dinit_out_t load_data,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dinit_pkg::dinit_out_t out_data
);
  import dinit_pkg::*;

  logic       valid_r, valid_nxt;
  dinit_out_t data_r;

  // a held request blocks new input only while the far side stalls
  assign busy      = valid_r & out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // valid flag: set on load, cleared once taken
  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

endmodule

// ----- bench/dinit_action_checker.sv -----
module dinit_action_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  dinit_pkg::dinit_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  dinit_pkg::dinit_out_t out_data,
  output int                    mismatches,
  output int                    actions_waiting,
  output int                    bytes_taken,
  output int                    actions_matched,
  output logic [7:0]            kinds_seen
);
  import dinit_pkg::*;

  // predicted parser state
  logic [2:0] phase;
  logic [7:0] run_left;
  logic       run_is_cmd;
  logic [1:0] trailing_data;
  logic [7:0] cmd_high;

  dinit_out_t expected_actions[$];
  int         fail_total;
  int         byte_total;
  int         match_total;
  logic [7:0] seen_total;

  task automatic clear_parser();
    phase         = PH_OPCODE;
    run_left      = '0;
    run_is_cmd    = 1'b0;
    trailing_data = '0;
    cmd_high      = '0;
  endtask

  // a command is done: go on to its data bytes, if any
  task automatic finish_command();
    if (trailing_data != 0) begin
      run_left   = {6'd0, trailing_data};
      run_is_cmd = 1'b0;
      phase      = PH_RUN;
    end else begin
      phase = PH_OPCODE;
    end
    trailing_data = '0;
  endtask

  // advance the parser by one list byte and give the action it causes
  task automatic decode_list_byte(input dinit_in_t req, output bit emits,
                                  output dinit_out_t act);
    logic [7:0] b;
    b     = req.op_byte;
    emits = 1'b0;
    act   = '0;
    case (phase)
      PH_CMD8: begin
        emits = 1'b1;
        act.action = ACT_CMD8;
        act.action_value = {8'd0, b};
        finish_command();
      end
      PH_C16_HI: begin
        cmd_high = b;
        phase    = PH_C16_LO;
      end
      PH_C16_LO: begin
        emits = 1'b1;
        act.action = ACT_CMD16;
        act.action_value = {cmd_high, b};
        finish_command();
      end
      PH_RUN_LEN: begin
        run_left = b;
        phase    = (b != 0) ? PH_RUN : PH_OPCODE;
      end
      PH_RUN: begin
        emits = 1'b1;
        act.action = run_is_cmd ? ACT_CBYTE : ACT_DBYTE;
        act.action_value = {8'd0, b};
        run_left = run_left - 8'd1;
        if (run_left == 0) phase = PH_OPCODE;
      end
      PH_DELAY: begin
        emits = 1'b1;
        act.action = ACT_DELAY;
        act.action_value = {8'd0, b};
        phase = PH_OPCODE;
      end
      PH_C8_LEN: begin
        emits = 1'b1;
        act.action = ACT_CMD8;
        act.action_value = {8'd0, b};
        run_is_cmd = 1'b0;
        phase      = PH_RUN_LEN;
      end
      default: begin
        phase = PH_OPCODE;
        case (b)
          OP_BEGIN: begin
            emits = 1'b1;
            act.action = ACT_BEGIN;
          end
          OP_END: begin
            emits = 1'b1;
            act.action = ACT_END;
          end
          OP_CMD8: begin
            trailing_data = 2'd0;
            phase = PH_CMD8;
          end
          OP_C8_D8: begin
            trailing_data = 2'd1;
            phase = PH_CMD8;
          end
          OP_C8_D16: begin
            trailing_data = 2'd2;
            phase = PH_CMD8;
          end
          OP_CMD16: begin
            trailing_data = 2'd0;
            phase = PH_C16_HI;
          end
          OP_C16_D16: begin
            trailing_data = 2'd2;
            phase = PH_C16_HI;
          end
          OP_CMD_RUN: begin
            run_is_cmd = 1'b1;
            phase = PH_RUN_LEN;
          end
          OP_DATA_RUN: begin
            run_is_cmd = 1'b0;
            phase = PH_RUN_LEN;
          end
          OP_DATA8: begin
            run_is_cmd = 1'b0;
            run_left = 8'd1;
            phase = PH_RUN;
          end
          OP_DATA16: begin
            run_is_cmd = 1'b0;
            run_left = 8'd2;
            phase = PH_RUN;
          end
          OP_C8_RUN: phase = PH_C8_LEN;
          OP_DELAY:  phase = PH_DELAY;
          default: begin
            emits = 1'b1;
            act.action = ACT_UNKNOWN;
            act.action_value = {8'd0, b};
          end
        endcase
      end
    endcase
    // the marked final byte drops whatever was half read
    if (req.last_in_list) clear_parser();
  endtask

  // predict on accepted requests, compare accepted actions in order
  always @(posedge clk) begin
    bit         emits;
    dinit_out_t act;
    dinit_out_t want;
    if (!rst_n) begin
      clear_parser();
      expected_actions.delete();
      fail_total  = 0;
      byte_total  = 0;
      match_total = 0;
      seen_total  = '0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_list_byte(in_data, emits, act);
        byte_total++;
        if (emits) expected_actions.push_back(act);
      end
      if (out_valid && !out_stall) begin
        if (expected_actions.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected action %0d value %h with nothing pending",
                     out_data.action, out_data.action_value);
        end else begin
          want = expected_actions.pop_front();
          if (out_data.action !== want.action ||
              out_data.action_value !== want.action_value) begin
            fail_total++;
            if (fail_total <= 10)
              $display("action mismatch: expected %0d/%h, got %0d/%h",
                       want.action, want.action_value,
                       out_data.action, out_data.action_value);
          end else begin
            match_total++;
            seen_total[want.action] = 1'b1;
          end
        end
      end
    end
    mismatches      <= fail_total;
    actions_waiting <= expected_actions.size();
    bytes_taken     <= byte_total;
    actions_matched <= match_total;
    kinds_seen      <= seen_total;
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import dinit_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 450;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  dinit_in_t  in_data   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  dinit_out_t out_data;

  int         mismatches;
  int         actions_waiting;
  int         bytes_taken;
  int         actions_matched;
  logic [7:0] kinds_seen;

  int cycle_count = 0;
  int stall_left  = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;

  // every opcode, mostly with extreme operands, ending in a long run cut short
  logic [7:0] directed_list[$] = '{
    OP_BEGIN,
    OP_CMD8, 8'hFF,
    OP_CMD16, 8'hFF, 8'h00,
    OP_CMD_RUN, 8'h01, 8'h00,
    OP_DATA8, 8'hFF,
    OP_DATA16, 8'h00, 8'hFF,
    OP_C8_D8, 8'h00, 8'hFF,
    OP_C8_D16, 8'hFF, 8'h00, 8'hFF,
    OP_C8_RUN, 8'h2C, 8'h00,
    OP_C16_D16, 8'h00, 8'hFF, 8'hA5, 8'h5A,
    OP_DELAY, 8'hFF,
    OP_END,
    8'hFF,
    OP_DATA_RUN, 8'hFF, 8'h5A
  };

  always #5 clk = ~clk;

  display_init_op_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  dinit_action_checker action_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .actions_waiting (actions_waiting),
    .bytes_taken     (bytes_taken),
    .actions_matched (actions_matched),
    .kinds_seen      (kinds_seen)
  );

  // mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // operand bytes lean toward the extremes
  function automatic logic [7:0] operand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= idle_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // one request, after an optional gap, held until taken
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = (tx_calm || $urandom_range(0, 3) != 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op_byte: b, last_in_list: last};
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every predicted action has come out
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (actions_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [7:0] op_bytes[$];
    logic [7:0] op;
    int         sent;
    int         n_ops;
    int         cut;
    int         extra;
    int         run_len;
    int         r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_list[i]) send_byte(directed_list[i], i == directed_list.size() - 1);
    pause_until_drained();

    // random lists of well-formed operations with some noise and cut lists
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      rx_calm = ($urandom_range(0, 5) == 0);
      n_ops   = $urandom_range(1, 8);
      for (int k = 0; k < n_ops; k++) begin
        op_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
          op_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 9) == 0)
            op = 8'($urandom_range(OP_DELAY + 1, 255));
          else
            op = 8'($urandom_range(OP_BEGIN, OP_DELAY));
          r = $urandom_range(0, 99);
          if (r < 60) run_len = $urandom_range(0, 3);
          else if (r < 90) run_len = $urandom_range(4, 12);
          else run_len = $urandom_range(13, 40);
          op_bytes.push_back(op);
          case (op) inside
            OP_CMD8, OP_DATA8, OP_DELAY:   extra = 1;
            OP_CMD16, OP_DATA16, OP_C8_D8: extra = 2;
            OP_C8_D16:                     extra = 3;
            OP_C16_D16:                    extra = 4;
            OP_CMD_RUN, OP_DATA_RUN: begin
              op_bytes.push_back(8'(run_len));
              extra = run_len;
            end
            OP_C8_RUN: begin
              op_bytes.push_back(operand_byte());
              op_bytes.push_back(8'(run_len));
              extra = run_len;
            end
            default: extra = 0;
          endcase
          repeat (extra) op_bytes.push_back(operand_byte());
        end
        // mark the list end, or now and then cut an operation short
        cut = -1;
        if ($urandom_range(0, 14) == 0)
          cut = $urandom_range(0, op_bytes.size() - 1);
        else if (k == n_ops - 1 && $urandom_range(0, 3) != 0)
          cut = op_bytes.size() - 1;
        foreach (op_bytes[i]) send_byte(op_bytes[i], i == cut);
        sent += op_bytes.size();
      end
      if ($urandom_range(0, 9) == 0) pause_until_drained();
    end

    // wind down and give the verdict
    rx_calm = 1'b0;
    pause_until_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d list bytes, %0d bus actions matched in order",
             bytes_taken, actions_matched);
    $display("action kinds seen (one bit per action code): %b", kinds_seen);
    if (actions_waiting != 0)
      $display("%0d predicted actions never came out", actions_waiting);
    if (mismatches == 0 && actions_waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dinit_pkg.sv
src/dinit_parser.sv
src/dinit_out_reg.sv
src/display_init_op_stream_decoder.sv
bench/dinit_action_checker.sv
bench/testbench.sv
